@@ hw/rtl/octl_pkg.sv @@
`timescale 1ns / 1ps

package octl_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int AVG_BITS    = 12;
    localparam int THR_BITS    = 12;
    localparam int COUNT_BITS  = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'hFFFF;

    localparam logic [THR_BITS-1:0]   THRESHOLD_A_RST = 12'd500;
    localparam logic [THR_BITS-1:0]   THRESHOLD_B_RST = 12'd500;
    localparam logic [COUNT_BITS-1:0] TRIP_TICKS_RST  = 16'd50;
    localparam logic [COUNT_BITS-1:0] CLEAR_TICKS_RST = 16'd1000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_THRESHOLD_A = 2'd0,
        REG_THRESHOLD_B = 2'd1,
        REG_TRIP_TICKS  = 2'd2,
        REG_CLEAR_TICKS = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_OVER   = 3'b010,
        MODE_FAULT  = 3'b100
    } mode_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_a_first;
        logic [SAMPLE_BITS-1:0] sample_a_second;
        logic [SAMPLE_BITS-1:0] sample_b_first;
        logic [SAMPLE_BITS-1:0] sample_b_second;
        logic                   clear_pressed;
    } tick_in_t;

    typedef struct packed {
        logic                fault_active;
        logic                cut_event;
        logic                resume_event;
        logic [AVG_BITS-1:0] average_a;
        logic [AVG_BITS-1:0] average_b;
    } tick_out_t;

    typedef struct packed {
        logic [THR_BITS-1:0]   threshold_a;
        logic [THR_BITS-1:0]   threshold_b;
        logic [COUNT_BITS-1:0] trip_ticks;
        logic [COUNT_BITS-1:0] clear_ticks;
    } cfg_t;

    function automatic logic [AVG_BITS-1:0] pair_mean(
        input logic [SAMPLE_BITS-1:0] x,
        input logic [SAMPLE_BITS-1:0] y
    );
        logic [SAMPLE_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        return AVG_BITS'(s[SAMPLE_BITS:1]);
    endfunction

endpackage

@@ hw/rtl/octl_core.sv @@
`timescale 1ns / 1ps

module octl_core import octl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  tick_in_t  item,
    input  cfg_t      cfg,
    output tick_out_t res
);

    mode_t                 mode_reg, mode_next;
    logic [COUNT_BITS-1:0] over_count_reg, over_count_next;
    logic [COUNT_BITS-1:0] hold_count_reg, hold_count_next;

    logic [AVG_BITS-1:0]   avg_a, avg_b;
    logic                  over_hit;
    logic [COUNT_BITS-1:0] over_inc;
    logic [COUNT_BITS-1:0] hold_upd;
    logic                  cut, resume;

    always_comb begin
        avg_a    = pair_mean(item.sample_a_first, item.sample_a_second);
        avg_b    = pair_mean(item.sample_b_first, item.sample_b_second);
        over_hit = (avg_a >= cfg.threshold_a) || (avg_b >= cfg.threshold_b);
        over_inc = over_count_reg + COUNT_BITS'(1);
        if (!item.clear_pressed) begin
            hold_upd = '0;
        end else if (hold_count_reg != COUNT_MAX) begin
            hold_upd = hold_count_reg + COUNT_BITS'(1);
        end else begin
            hold_upd = hold_count_reg;
        end

        mode_next       = mode_reg;
        over_count_next = over_count_reg;
        hold_count_next = hold_count_reg;
        cut             = 1'b0;
        resume          = 1'b0;

        unique case (mode_reg)
            MODE_OVER: begin
                if (!over_hit) begin
                    over_count_next = '0;
                    mode_next       = MODE_NORMAL;
                end else begin
                    over_count_next = over_inc;
                    if (over_inc >= cfg.trip_ticks) begin
                        cut             = 1'b1;
                        hold_count_next = '0;
                        mode_next       = MODE_FAULT;
                    end
                end
            end
            MODE_FAULT: begin
                hold_count_next = hold_upd;
                if (hold_upd >= cfg.clear_ticks) begin
                    resume          = 1'b1;
                    hold_count_next = '0;
                    over_count_next = '0;
                    mode_next       = MODE_NORMAL;
                end
            end
            default: begin
                mode_next = MODE_NORMAL;
                if (over_hit) begin
                    over_count_next = COUNT_BITS'(1);
                    mode_next       = MODE_OVER;
                end
            end
        endcase

        res.fault_active = (mode_next == MODE_FAULT);
        res.cut_event    = cut;
        res.resume_event = resume;
        res.average_a    = avg_a;
        res.average_b    = avg_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_NORMAL;
            over_count_reg <= '0;
            hold_count_reg <= '0;
        end else if (step) begin
            mode_reg       <= mode_next;
            over_count_reg <= over_count_next;
            hold_count_reg <= hold_count_next;
        end
    end

    a_cut_enters_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.cut_event |=> mode_reg == MODE_FAULT)
        else $error("cut without entering fault");

    a_cut_resume_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> !(res.cut_event && res.resume_event))
        else $error("cut and resume in one beat");

    a_resume_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.resume_event |=>
            mode_reg == MODE_NORMAL && over_count_reg == '0 && hold_count_reg == '0)
        else $error("resume left counters set");

    a_hold_only_in_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg != MODE_FAULT |-> hold_count_reg == '0)
        else $error("hold count outside fault");

endmodule

@@ hw/rtl/overcurrent_trip_latch_top.sv @@
`timescale 1ns / 1ps

// Overcurrent trip latch. Each input beat is one tick holding two raw samples per channel
// and the clear-button level; each produces exactly one result beat with the fault flag,
// cut/resume pulses and both pair averages. The input register feeds the averaging, threshold
// compare and trip/clear state machine, whose result is held in the output register; a beat
// is accepted every cycle and throughput is one beat per cycle while m_ready is high.
// Configuration writes (index 0..3: threshold_a, threshold_b, trip_ticks, clear_ticks) are
// always ready; a write whose field bits are zero is ignored.

module overcurrent_trip_latch_top import octl_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  tick_in_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output tick_out_t                m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    cfg_t      cfg_reg;
    logic      in_valid_reg;
    tick_in_t  in_data_reg;
    logic      out_valid_reg;
    tick_out_t out_data_reg;
    tick_out_t core_res;
    logic      step;
    logic      out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_ready;
    assign step      = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold_a <= THRESHOLD_A_RST;
            cfg_reg.threshold_b <= THRESHOLD_B_RST;
            cfg_reg.trip_ticks  <= TRIP_TICKS_RST;
            cfg_reg.clear_ticks <= CLEAR_TICKS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD_A: begin
                    if (cfg_wdata[THR_BITS-1:0] != '0)
                        cfg_reg.threshold_a <= cfg_wdata[THR_BITS-1:0];
                end
                REG_THRESHOLD_B: begin
                    if (cfg_wdata[THR_BITS-1:0] != '0)
                        cfg_reg.threshold_b <= cfg_wdata[THR_BITS-1:0];
                end
                REG_TRIP_TICKS: begin
                    if (cfg_wdata[COUNT_BITS-1:0] != '0)
                        cfg_reg.trip_ticks <= cfg_wdata[COUNT_BITS-1:0];
                end
                REG_CLEAR_TICKS: begin
                    if (cfg_wdata[COUNT_BITS-1:0] != '0)
                        cfg_reg.clear_ticks <= cfg_wdata[COUNT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= core_res;
        end
    end

    octl_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .res     (core_res)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import octl_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int SAMPLE_TOP    = (1 << SAMPLE_BITS) - 1;
    localparam int RANDOM_PHASES = 12;
    localparam int EXTREME_PHASE = 3;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    tick_in_t                 s_data    = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    tick_out_t                m_data;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = REG_THRESHOLD_A;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    always #5 aclk = ~aclk;

    overcurrent_trip_latch_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // trip predictor: settings and state
    logic [THR_BITS-1:0]   thr_a       = THRESHOLD_A_RST;
    logic [THR_BITS-1:0]   thr_b       = THRESHOLD_B_RST;
    logic [COUNT_BITS-1:0] trip_limit  = TRIP_TICKS_RST;
    logic [COUNT_BITS-1:0] clear_limit = CLEAR_TICKS_RST;
    mode_t                 trip_mode   = MODE_NORMAL;
    logic [COUNT_BITS-1:0] over_ticks  = '0;
    logic [COUNT_BITS-1:0] held_ticks  = '0;

    tick_in_t  pending_ticks[$];
    tick_out_t expected_ticks[$];

    int unsigned issued       = 0;
    int unsigned results_seen = 0;
    int unsigned fails        = 0;
    int unsigned trips_seen   = 0;
    int unsigned clears_seen  = 0;
    int unsigned reg_writes   = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    bit          calm         = 1'b0;
    int unsigned src_gap      = 0;
    int unsigned sink_gap     = 0;
    int unsigned quiet_cycles = 0;

    function automatic tick_out_t trip_latch_step(input tick_in_t t);
        logic [SAMPLE_BITS:0] sum_a;
        logic [SAMPLE_BITS:0] sum_b;
        logic [AVG_BITS-1:0]  avg_a;
        logic [AVG_BITS-1:0]  avg_b;
        logic                 hot;
        tick_out_t            r;
        sum_a = {1'b0, t.sample_a_first} + {1'b0, t.sample_a_second};
        sum_b = {1'b0, t.sample_b_first} + {1'b0, t.sample_b_second};
        avg_a = sum_a[SAMPLE_BITS:1];
        avg_b = sum_b[SAMPLE_BITS:1];
        hot = (avg_a >= thr_a) || (avg_b >= thr_b);
        r = '0;
        case (trip_mode)
            MODE_OVER: begin
                if (!hot) begin
                    over_ticks = '0;
                    trip_mode = MODE_NORMAL;
                end else begin
                    over_ticks = over_ticks + 1'b1;
                    if (over_ticks >= trip_limit) begin
                        r.cut_event = 1'b1;
                        held_ticks = '0;
                        trip_mode = MODE_FAULT;
                    end
                end
            end
            MODE_FAULT: begin
                if (t.clear_pressed) begin
                    if (held_ticks != COUNT_MAX) held_ticks = held_ticks + 1'b1;
                end else begin
                    held_ticks = '0;
                end
                if (held_ticks >= clear_limit) begin
                    r.resume_event = 1'b1;
                    held_ticks = '0;
                    over_ticks = '0;
                    trip_mode = MODE_NORMAL;
                end
            end
            default: begin
                trip_mode = MODE_NORMAL;
                if (hot) begin
                    over_ticks = COUNT_BITS'(1);
                    trip_mode = MODE_OVER;
                end
            end
        endcase
        r.fault_active = (trip_mode == MODE_FAULT);
        r.average_a = avg_a;
        r.average_b = avg_b;
        return r;
    endfunction

    function automatic void load_setting(input cfg_reg_t idx, input logic [15:0] value);
        case (idx)
            REG_THRESHOLD_A: if (value[THR_BITS-1:0] != 0) thr_a = value[THR_BITS-1:0];
            REG_THRESHOLD_B: if (value[THR_BITS-1:0] != 0) thr_b = value[THR_BITS-1:0];
            REG_TRIP_TICKS:  if (value != 0) trip_limit = value;
            REG_CLEAR_TICKS: if (value != 0) clear_limit = value;
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            fails++;
        end
    endfunction

    function automatic void queue_tick(input tick_in_t t);
        pending_ticks.push_back(t);
        issued++;
    endfunction

    function automatic tick_in_t tick_of(input int unsigned a1, input int unsigned a2,
                                         input int unsigned b1, input int unsigned b2,
                                         input bit press);
        tick_in_t t;
        t.sample_a_first  = SAMPLE_BITS'(a1);
        t.sample_a_second = SAMPLE_BITS'(a2);
        t.sample_b_first  = SAMPLE_BITS'(b1);
        t.sample_b_second = SAMPLE_BITS'(b2);
        t.clear_pressed   = press;
        return t;
    endfunction

    // two samples whose floor mean is avg
    function automatic logic [2*SAMPLE_BITS-1:0] pair_for(input int unsigned avg);
        int unsigned total;
        int unsigned lo;
        int unsigned hi;
        int unsigned x;
        total = 2 * avg + $urandom_range(1);
        if (total > 2 * SAMPLE_TOP) total = 2 * SAMPLE_TOP;
        lo = (total > SAMPLE_TOP) ? total - SAMPLE_TOP : 0;
        hi = (total < SAMPLE_TOP) ? total : SAMPLE_TOP;
        x = $urandom_range(hi, lo);
        return {SAMPLE_BITS'(x), SAMPLE_BITS'(total - x)};
    endfunction

    function automatic int unsigned pick_avg(input int unsigned thr, input bit hot);
        if (hot) return ($urandom_range(3) == 0) ? thr : $urandom_range(SAMPLE_TOP, thr);
        return ($urandom_range(3) == 0) ? thr - 1 : $urandom_range(thr - 1, 0);
    endfunction

    function automatic tick_in_t make_tick(input bit hot, input bit press);
        tick_in_t    t;
        int unsigned which;
        which = hot ? $urandom_range(2) : 3;
        {t.sample_a_first, t.sample_a_second} = pair_for(pick_avg(thr_a, which != 1 && hot));
        {t.sample_b_first, t.sample_b_second} = pair_for(pick_avg(thr_b, which != 0 && hot));
        t.clear_pressed = press;
        return t;
    endfunction

    // mostly trip-then-clear sequences; some short over runs and some noise
    function automatic void add_episode(input bit force_trip);
        int unsigned kind;
        int unsigned n;
        tick_in_t    t;
        kind = force_trip ? 0 : $urandom_range(9);
        if (kind < 7) begin
            n = (trip_limit > 60) ? 40 : trip_limit + 1;
            repeat (n) queue_tick(make_tick(1'b1, 1'($urandom_range(1))));
            n = (clear_limit > 40) ? 40 : clear_limit + $urandom_range(2);
            repeat (n) queue_tick(make_tick(1'($urandom_range(1)), $urandom_range(9) != 0));
            repeat ($urandom_range(3, 1)) queue_tick(make_tick(1'b0, 1'($urandom_range(1))));
        end else if (kind < 9) begin
            n = (trip_limit > 40) ? 40 : trip_limit;
            repeat ($urandom_range(n, 1)) queue_tick(make_tick(1'b1, 1'($urandom_range(1))));
            queue_tick(make_tick(1'b0, 1'($urandom_range(1))));
        end else begin
            repeat ($urandom_range(5, 1)) begin
                t.sample_a_first  = SAMPLE_BITS'($urandom);
                t.sample_a_second = SAMPLE_BITS'($urandom);
                t.sample_b_first  = SAMPLE_BITS'($urandom);
                t.sample_b_second = SAMPLE_BITS'($urandom);
                t.clear_pressed   = 1'($urandom_range(1));
                queue_tick(t);
            end
        end
    endfunction

    function automatic logic [15:0] random_thr_word();
        case ($urandom_range(7))
            0:       return {4'($urandom), 12'd1};
            1:       return {4'($urandom), 12'hFFF};
            2:       return 16'd0;
            default: return {4'($urandom), 12'($urandom_range(SAMPLE_TOP, 1))};
        endcase
    endfunction

    function automatic logic [15:0] random_count_word();
        case ($urandom_range(11))
            0:       return 16'($urandom);
            1:       return 16'd0;
            default: return 16'($urandom_range(12, 1));
        endcase
    endfunction

    function automatic int unsigned pick_idle_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        load_setting(idx, value);
        reg_writes++;
    endtask

    task automatic drain_ticks();
        while (results_seen < issued) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // tick beat driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_valid && s_ready)
                expected_ticks.push_back(trip_latch_step(s_data));
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (pending_ticks.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(99) < src_idle_pct) begin
                    src_gap = $urandom_range(6);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_data <= pending_ticks.pop_front();
                end
            end
        end
    end

    // result beat monitor
    always @(posedge aclk) begin : result_check
        tick_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_ticks.size() == 0) begin
                    $display("%0t: result beat with no tick outstanding, got %h", $time, m_data);
                    fails++;
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("fault_active", want.fault_active, m_data.fault_active);
                    check_field("cut_event", want.cut_event, m_data.cut_event);
                    check_field("resume_event", want.resume_event, m_data.resume_event);
                    check_field("average_a", want.average_a, m_data.average_a);
                    check_field("average_b", want.average_b, m_data.average_b);
                    trips_seen += want.cut_event;
                    clears_seen += want.resume_event;
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(99) < sink_stall_pct) begin
                sink_gap = $urandom_range(6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
                $display("overcurrent_trip_latch_top: mismatch");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int unsigned start;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: threshold edges, sample extremes, odd pair sums
        queue_tick(tick_of(0, 0, 0, 0, 0));
        queue_tick(tick_of(4095, 4095, 4095, 4095, 1));
        queue_tick(tick_of(499, 500, 1, 0, 0));
        queue_tick(tick_of(500, 501, 0, 0, 1));
        queue_tick(tick_of(0, 0, 500, 500, 0));
        queue_tick(tick_of(2, 1, 998, 1, 0));
        add_episode(1'b1);
        drain_ticks();

        // masked-to-zero and zero writes leave thresholds at 500
        write_reg(REG_THRESHOLD_A, 16'hF000);
        write_reg(REG_THRESHOLD_B, 16'h0000);
        write_reg(REG_TRIP_TICKS, 16'd1);
        write_reg(REG_CLEAR_TICKS, 16'd1);
        cfg_valid <= 1'b0;
        queue_tick(tick_of(0, 0, 0, 0, 1));
        queue_tick(tick_of(499, 500, 1000, 0, 0));
        queue_tick(tick_of(4095, 0, 0, 0, 0));
        queue_tick(tick_of(3, 4, 5, 6, 1));
        queue_tick(tick_of(600, 601, 0, 0, 1));
        queue_tick(tick_of(0, 0, 4095, 4094, 0));
        queue_tick(tick_of(0, 0, 0, 0, 0));
        queue_tick(tick_of(4095, 4095, 4095, 4095, 1));
        queue_tick(tick_of(1, 1, 1, 1, 0));
        drain_ticks();

        write_reg(REG_THRESHOLD_A, 16'hF001);
        write_reg(REG_THRESHOLD_B, 16'h0FFF);
        write_reg(REG_TRIP_TICKS, 16'd2);
        write_reg(REG_TRIP_TICKS, 16'd0);
        write_reg(REG_CLEAR_TICKS, 16'd3);
        write_reg(REG_CLEAR_TICKS, 16'd0);
        cfg_valid <= 1'b0;
        queue_tick(tick_of(0, 1, 4094, 4095, 1));
        queue_tick(tick_of(1, 1, 0, 0, 0));
        queue_tick(tick_of(0, 0, 4095, 4095, 0));
        queue_tick(tick_of(0, 0, 0, 0, 1));
        queue_tick(tick_of(0, 0, 0, 0, 0));
        queue_tick(tick_of(0, 0, 0, 0, 1));
        queue_tick(tick_of(0, 0, 0, 0, 1));
        queue_tick(tick_of(0, 0, 0, 0, 1));
        drain_ticks();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            src_idle_pct = pick_idle_pct();
            sink_stall_pct = pick_idle_pct();
            calm = (p >= RANDOM_PHASES - 2);
            if (p == EXTREME_PHASE) begin
                write_reg(REG_THRESHOLD_A, 16'h0FFF);
                write_reg(REG_THRESHOLD_B, 16'h0001);
                write_reg(REG_TRIP_TICKS, 16'hFFFF);
                write_reg(REG_CLEAR_TICKS, 16'hFFFF);
            end else begin
                write_reg(REG_THRESHOLD_A, random_thr_word());
                write_reg(REG_THRESHOLD_B, random_thr_word());
                write_reg(REG_TRIP_TICKS, random_count_word());
                write_reg(REG_CLEAR_TICKS, random_count_word());
            end
            cfg_valid <= 1'b0;
            start = issued;
            while (issued - start < 30) add_episode(1'b0);
            drain_ticks();
        end

        repeat (8) @(posedge aclk);
        if (expected_ticks.size() != 0) begin
            $display("%0t: %0d tick results never arrived", $time, expected_ticks.size());
            fails += expected_ticks.size();
        end
        $display("%0d tick results checked, with %0d trips and %0d clears",
                 results_seen, trips_seen, clears_seen);
        $display("%0d register writes over %0d settings, zero and masked writes included",
                 reg_writes, RANDOM_PHASES + 3);
        if (fails == 0) begin
            $display("overcurrent_trip_latch_top: match");
        end else begin
            $display("overcurrent_trip_latch_top: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/octl_pkg.sv
hw/rtl/octl_core.sv
hw/rtl/overcurrent_trip_latch_top.sv
tb/tb.sv
